[design/trsm_pkg.sv]
package trsm_pkg;

	// Most results that one accepted item may produce.
	localparam int MAX_RESULTS = 32;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	// Command codes of an input item.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_END = 1'b1;

	// Run select codes; run A wins ties.
	localparam logic RUN_A = 1'b0;
	localparam logic RUN_B = 1'b1;

	// Merge sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OVF,
		ST_FETCH,
		ST_DECIDE
	} state_t;

endpackage

[design/trsm_if.sv]
// Input channel: one push or end-of-run command per transfer.
interface trsm_in_if #(
	parameter int WORD_BITS = 32
);
	logic valid;
	logic ready;
	logic cmd;
	logic run_select;
	logic signed [WORD_BITS-1:0] word;

	modport source (output valid, output cmd, output run_select, output word, input ready);
	modport sink (input valid, input cmd, input run_select, input word, output ready);
endinterface

// Output channel: one merged word or status result per transfer.
interface trsm_out_if #(
	parameter int WORD_BITS = 32
);
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] merged_word;
	logic last_of_merge;
	logic no_data;
	logic overflow;

	modport source (output valid, output merged_word, output last_of_merge,
		output no_data, output overflow, input ready);
	modport sink (input valid, input merged_word, input last_of_merge,
		input no_data, input overflow, output ready);
endinterface

[design/trsm_run_buf.sv]
// Word store of one run: one write port, one registered read port.
module trsm_run_buf #(
	parameter int DEPTH = 32,
	parameter int WORD_BITS = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [WORD_BITS-1:0] wr_data,
	input logic [AW-1:0] rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[design/two_run_stable_merge.sv]
// Stable merge of two ascending runs of signed words.
// The item channel carries commands: push a word onto run A or run B, or
// mark the end of a run. The result channel returns the merged words in
// ascending order, with run A winning ties; the final word of a merge has
// last_of_merge set. If both runs end empty, a single no_data result is
// given instead. A push into a full run is dropped and reported by one
// result with overflow set; a push into an ended run is ignored.
// Sequencing: an item is taken in ST_IDLE, and the block then works on it
// before it accepts the next. Each emitted word passes ST_FETCH, for the
// registered read of both run heads, then ST_DECIDE, for the compare and
// pop, so the run memories' read latency sets the rate. An overflow report
// adds ST_OVF; an item with no result runs ST_FETCH, ST_DECIDE, ST_IDLE.
// One item emits at most 32 results; words still due wait for the next item.
// Results sit in an output register, so a stalled receiver only holds the
// sequencer when a new result is due. Reset empties both runs and the
// output register; memory contents are not cleared and need no sweep.
module two_run_stable_merge
	import trsm_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32,
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	trsm_in_if.sink item,
	trsm_out_if.source result
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	state_t state_q, state_d;
	logic [IDX_W-1:0] head_q [2];
	logic [IDX_W-1:0] head_d [2];
	logic [CNT_W-1:0] count_q [2];
	logic [CNT_W-1:0] count_d [2];
	logic ended_q [2];
	logic ended_d [2];
	logic [RES_CNT_W-1:0] n_q, n_d;

	logic out_valid_q;
	logic [WORD_BITS-1:0] out_word_q, out_word_d;
	logic out_last_q, out_last_d;
	logic out_nodata_q, out_nodata_d;
	logic out_ovf_q, out_ovf_d;
	logic out_load;
	logic slot_free;

	logic [WORD_BITS-1:0] rd_data [2];
	logic [IDX_W:0] tail_sum;
	logic [IDX_W-1:0] tail_addr;
	logic push_ok;
	logic pop_a, pop_b, pop_run;
	logic [CNT_W-1:0] cnt_after [2];

	// Write address of a push: head plus count, wrapped once.
	always_comb begin
		tail_sum = (IDX_W+1)'(head_q[item.run_select]) + (IDX_W+1)'(count_q[item.run_select]);
		if (tail_sum >= (IDX_W+1)'(BUFFER_DEPTH)) begin
			tail_sum = tail_sum - (IDX_W+1)'(BUFFER_DEPTH);
		end
		tail_addr = tail_sum[IDX_W-1:0];
	end

	assign push_ok = item.valid && (state_q == ST_IDLE) && (item.cmd == CMD_PUSH)
		&& !ended_q[item.run_select]
		&& (count_q[item.run_select] != CNT_W'(BUFFER_DEPTH));

	// One memory per run, both read at their current heads.
	for (genvar r = 0; r < 2; r++) begin : g_run
		trsm_run_buf #(
			.DEPTH(BUFFER_DEPTH),
			.WORD_BITS(WORD_BITS)
		) u_buf (
			.clk(clk),
			.wr_en(push_ok && (item.run_select == 1'(r))),
			.wr_addr(tail_addr),
			.wr_data(item.word),
			.rd_addr(head_q[r]),
			.rd_data(rd_data[r])
		);
	end

	assign item.ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || result.ready;

	// Pop choice from the two head words read in the previous cycle.
	always_comb begin
		pop_a = 1'b0;
		pop_b = 1'b0;
		if (count_q[RUN_A] != '0 && count_q[RUN_B] != '0) begin
			if ($signed(rd_data[RUN_A]) <= $signed(rd_data[RUN_B])) begin
				pop_a = 1'b1;
			end else begin
				pop_b = 1'b1;
			end
		end else if (count_q[RUN_A] != '0 && ended_q[RUN_B]) begin
			pop_a = 1'b1;
		end else if (count_q[RUN_B] != '0 && ended_q[RUN_A]) begin
			pop_b = 1'b1;
		end
		pop_run = pop_b ? RUN_B : RUN_A;
	end

	// Sequencer: next state, run bookkeeping and result loading.
	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		ended_d = ended_q;
		n_d = n_q;
		out_load = 1'b0;
		out_word_d = '0;
		out_last_d = 1'b0;
		out_nodata_d = 1'b0;
		out_ovf_d = 1'b0;
		cnt_after = count_q;

		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					n_d = '0;
					state_d = ST_FETCH;
					if (item.cmd == CMD_END) begin
						ended_d[item.run_select] = 1'b1;
					end else if (!ended_q[item.run_select]) begin
						if (count_q[item.run_select] == CNT_W'(BUFFER_DEPTH)) begin
							state_d = ST_OVF;
						end else begin
							count_d[item.run_select] = count_q[item.run_select] + 1'b1;
						end
					end
				end
			end
			ST_OVF: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_ovf_d = 1'b1;
					n_d = RES_CNT_W'(1);
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (n_q == RES_CNT_W'(MAX_RESULTS)) begin
					state_d = ST_IDLE;
				end else if (pop_a || pop_b) begin
					if (slot_free) begin
						cnt_after[pop_run] = count_q[pop_run] - 1'b1;
						count_d[pop_run] = cnt_after[pop_run];
						head_d[pop_run] = (head_q[pop_run] == IDX_W'(BUFFER_DEPTH - 1))
							? '0 : head_q[pop_run] + 1'b1;
						out_load = 1'b1;
						out_word_d = rd_data[pop_run];
						n_d = n_q + 1'b1;
						state_d = ST_FETCH;
						// Last word of a finished merge: clear for the next one.
						if (ended_q[RUN_A] && ended_q[RUN_B]
							&& cnt_after[RUN_A] == '0 && cnt_after[RUN_B] == '0) begin
							out_last_d = 1'b1;
							head_d[RUN_A] = '0;
							head_d[RUN_B] = '0;
							ended_d[RUN_A] = 1'b0;
							ended_d[RUN_B] = 1'b0;
						end
					end
				end else if (ended_q[RUN_A] && ended_q[RUN_B]
					&& count_q[RUN_A] == '0 && count_q[RUN_B] == '0) begin
					// Both runs ended empty.
					if (slot_free) begin
						out_load = 1'b1;
						out_last_d = 1'b1;
						out_nodata_d = 1'b1;
						head_d[RUN_A] = '0;
						head_d[RUN_B] = '0;
						ended_d[RUN_A] = 1'b0;
						ended_d[RUN_B] = 1'b0;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < 2; r++) begin
				head_q[r] <= '0;
				count_q[r] <= '0;
				ended_q[r] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			n_q <= n_d;
			head_q <= head_d;
			count_q <= count_d;
			ended_q <= ended_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= out_word_d;
			out_last_q <= out_last_d;
			out_nodata_q <= out_nodata_d;
			out_ovf_q <= out_ovf_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.merged_word = out_word_q;
	assign result.last_of_merge = out_last_q;
	assign result.no_data = out_nodata_q;
	assign result.overflow = out_ovf_q;

endmodule
